// ===== src/rss_pkg.sv =====
// Shared types and constants for the replicated-share dot product block.
`timescale 1ns / 1ps
package rss_pkg;

  localparam int FIELD_W    = 64;  // width of every share, mask and result field
  localparam int PARTIES    = 3;   // number of parties, one lane each
  localparam int LANE_DEPTH = 4;   // register stages inside one lane

  typedef struct packed {
    logic valid;
    logic last;
  } rss_ctl_t;

endpackage

// ===== src/rss_in_if.sv =====
// Input channel: x and y shares, masks and the last flag.
`timescale 1ns / 1ps
interface rss_in_if import rss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] x_share0;
  logic [FIELD_W-1:0] x_share1;
  logic [FIELD_W-1:0] x_share2;
  logic [FIELD_W-1:0] y_share0;
  logic [FIELD_W-1:0] y_share1;
  logic [FIELD_W-1:0] y_share2;
  logic [FIELD_W-1:0] mask0;
  logic [FIELD_W-1:0] mask1;
  logic [FIELD_W-1:0] mask2;
  logic               last;

  modport source (
    output valid, x_share0, x_share1, x_share2, y_share0, y_share1, y_share2,
           mask0, mask1, mask2, last,
    input  ready
  );

  modport sink (
    input  valid, x_share0, x_share1, x_share2, y_share0, y_share1, y_share2,
           mask0, mask1, mask2, last,
    output ready
  );
endinterface

// ===== src/rss_out_if.sv =====
// Result channel: one masked output share per party.
`timescale 1ns / 1ps
interface rss_out_if import rss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] z_share0;
  logic [FIELD_W-1:0] z_share1;
  logic [FIELD_W-1:0] z_share2;

  modport source (
    output valid, z_share0, z_share1, z_share2,
    input  ready
  );

  modport sink (
    input  valid, z_share0, z_share1, z_share2,
    output ready
  );
endinterface

// ===== src/rss_lane.sv =====
// One party lane: x_p*(y_p+y_q) + x_q*y_p mod 2^EW over split partial products.
`timescale 1ns / 1ps
module rss_lane import rss_pkg::*; #(
  parameter int EW = 64
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [EW-1:0] x_p,
  input  logic [EW-1:0] x_q,
  input  logic [EW-1:0] y_p,
  input  logic [EW-1:0] y_q,
  input  logic [EW-1:0] mask,
  output logic [EW-1:0] term,
  output logic [EW-1:0] term_m
);

  localparam int HI_W = EW / 2;
  localparam int LO_W = EW - HI_W;
  localparam int PW   = 2 * LO_W;

  // stage A: operands
  logic [EW-1:0] a1_r, b1_r, a2_r, b2_r, ma_r;
  // stage B: partial products
  logic [PW-1:0]   ll1_r, ll2_r;
  logic [HI_W-1:0] hl1_r, lh1_r, hl2_r, lh2_r;
  logic [EW-1:0]   mb_r;
  // stage C: the two products
  logic [EW-1:0] p1_r, p2_r, mc_r;
  // stage D: lane sum, with and without the mask
  logic [EW-1:0] term_r, term_m_r;

  logic [PW-1:0] ll1_w, ll2_w;
  logic [EW-1:0] hl1_w, lh1_w, hl2_w, lh2_w;

  // low half times low half, kept whole; cross terms only matter below 2^(EW-LO_W)
  assign ll1_w = PW'(a1_r[LO_W-1:0]) * PW'(b1_r[LO_W-1:0]);
  assign hl1_w = EW'(a1_r[EW-1:LO_W]) * EW'(b1_r[LO_W-1:0]);
  assign lh1_w = EW'(a1_r[LO_W-1:0]) * EW'(b1_r[EW-1:LO_W]);
  assign ll2_w = PW'(a2_r[LO_W-1:0]) * PW'(b2_r[LO_W-1:0]);
  assign hl2_w = EW'(a2_r[EW-1:LO_W]) * EW'(b2_r[LO_W-1:0]);
  assign lh2_w = EW'(a2_r[LO_W-1:0]) * EW'(b2_r[EW-1:LO_W]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r     <= x_p;
      b1_r     <= y_p + y_q;
      a2_r     <= x_q;
      b2_r     <= y_p;
      ma_r     <= mask;

      ll1_r    <= ll1_w;
      hl1_r    <= hl1_w[HI_W-1:0];
      lh1_r    <= lh1_w[HI_W-1:0];
      ll2_r    <= ll2_w;
      hl2_r    <= hl2_w[HI_W-1:0];
      lh2_r    <= lh2_w[HI_W-1:0];
      mb_r     <= ma_r;

      p1_r     <= ll1_r[EW-1:0] + {(hl1_r + lh1_r), {LO_W{1'b0}}};
      p2_r     <= ll2_r[EW-1:0] + {(hl2_r + lh2_r), {LO_W{1'b0}}};
      mc_r     <= mb_r;

      term_r   <= p1_r + p2_r;
      term_m_r <= p1_r + p2_r + mc_r;
    end
  end

  assign term   = term_r;
  assign term_m = term_m_r;

endmodule

// ===== src/rss_merge.sv =====
// Party accumulators, result register and pipeline advance control.
`timescale 1ns / 1ps
module rss_merge import rss_pkg::*; #(
  parameter int EW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rss_ctl_t      ctl,
  input  logic [EW-1:0] term   [PARTIES],
  input  logic [EW-1:0] term_m [PARTIES],
  input  logic          out_ready,
  output logic          adv,
  output logic          out_valid,
  output logic [EW-1:0] z      [PARTIES]
);

  logic [EW-1:0] acc_r   [PARTIES];
  logic [EW-1:0] acc_nxt [PARTIES];
  logic [EW-1:0] z_r     [PARTIES];
  logic [EW-1:0] z_nxt   [PARTIES];
  logic          out_valid_r, out_valid_nxt;
  logic          take;

  // hold the whole pipeline only when a finished sum has nowhere to go
  assign adv  = !(ctl.valid && ctl.last && out_valid_r && !out_ready);
  assign take = adv && ctl.valid;

  always_comb begin
    for (int p = 0; p < PARTIES; p++) begin
      acc_nxt[p] = acc_r[p];
      z_nxt[p]   = z_r[p];
      if (take) begin
        acc_nxt[p] = ctl.last ? '0 : acc_r[p] + term[p];
        if (ctl.last) begin
          z_nxt[p] = acc_r[p] + term_m[p];
        end
      end
    end
    if (take && ctl.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int p = 0; p < PARTIES; p++) begin
        acc_r[p] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int p = 0; p < PARTIES; p++) begin
        acc_r[p] <= acc_nxt[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PARTIES; p++) begin
      z_r[p] <= z_nxt[p];
    end
  end

  assign out_valid = out_valid_r;
  assign z         = z_r;

endmodule

// ===== src/replicated_share_dot_product.sv =====
// Top level of the three-party replicated-share multiply-accumulate block.
`timescale 1ns / 1ps
// Takes one item per clock while input ready is high. The transfer edge loads
// the first of four register stages in each party lane (operand and share sum,
// split half-width partial products, product assembly, lane sum with and without
// the mask). The last lane stage loads the party accumulators and, for an item
// that carries last, the output register. Three lanes run
// side by side, one per party.
// Input ready drops only while a result sits unread in the output register
// and another last item has reached the last lane stage. Arithmetic wraps at
// min(RING_BITS, 64) bits; bits above that in the result fields read zero.
module replicated_share_dot_product import rss_pkg::*; #(
  parameter int RING_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  rss_in_if.sink           in_ch,
  rss_out_if.source        out_ch
);

  localparam int EW = (RING_BITS < FIELD_W) ? RING_BITS : FIELD_W;

  logic [EW-1:0] x_s    [PARTIES];
  logic [EW-1:0] y_s    [PARTIES];
  logic [EW-1:0] m_s    [PARTIES];
  logic [EW-1:0] term   [PARTIES];
  logic [EW-1:0] term_m [PARTIES];
  logic [EW-1:0] z      [PARTIES];
  rss_ctl_t      ctl_r  [LANE_DEPTH];
  logic          adv;
  logic          out_valid;

  assign x_s[0] = in_ch.x_share0[EW-1:0];
  assign x_s[1] = in_ch.x_share1[EW-1:0];
  assign x_s[2] = in_ch.x_share2[EW-1:0];
  assign y_s[0] = in_ch.y_share0[EW-1:0];
  assign y_s[1] = in_ch.y_share1[EW-1:0];
  assign y_s[2] = in_ch.y_share2[EW-1:0];
  assign m_s[0] = in_ch.mask0[EW-1:0];
  assign m_s[1] = in_ch.mask1[EW-1:0];
  assign m_s[2] = in_ch.mask2[EW-1:0];

  assign in_ch.ready = adv;

  for (genvar p = 0; p < PARTIES; p++) begin : g_lane
    localparam int Q = (p + 1) % PARTIES;
    rss_lane #(.EW(EW)) u_lane (
      .clk    (clk),
      .adv    (adv),
      .x_p    (x_s[p]),
      .x_q    (x_s[Q]),
      .y_p    (y_s[p]),
      .y_q    (y_s[Q]),
      .mask   (m_s[p]),
      .term   (term[p]),
      .term_m (term_m[p])
    );
  end

  // valid and last ride alongside the lane data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_DEPTH; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0].valid <= in_ch.valid;
      ctl_r[0].last  <= in_ch.last;
      for (int k = 1; k < LANE_DEPTH; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  rss_merge #(.EW(EW)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r[LANE_DEPTH-1]),
    .term      (term),
    .term_m    (term_m),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_valid (out_valid),
    .z         (z)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.z_share0 = FIELD_W'(z[0]);
  assign out_ch.z_share1 = FIELD_W'(z[1]);
  assign out_ch.z_share2 = FIELD_W'(z[2]);

endmodule

// ===== src/rss_chk.sv =====
// Port-level checks for the replicated-share dot product block, bound to the top level.
`timescale 1ns / 1ps
module rss_chk import rss_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] z_share0,
  input logic [FIELD_W-1:0] z_share1,
  input logic [FIELD_W-1:0] z_share2
);

  // reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result that is not taken holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(z_share0) && $stable(z_share1)
                                && $stable(z_share2))
    else $error("stalled result changed");

  // input stalls only while a result waits unread
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // a fresh result comes from a cycle in which the pipeline moved
  a_rise_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result appeared from a held pipeline");

endmodule

bind replicated_share_dot_product rss_chk u_rss_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .z_share0  (out_ch.z_share0),
  .z_share1  (out_ch.z_share1),
  .z_share2  (out_ch.z_share2)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the replicated-share multiply-accumulate block.
`timescale 1ns / 1ps
module tb;
  import rss_pkg::*;

  localparam int RING_BITS  = 64;
  localparam logic [FIELD_W-1:0] RING_MASK =
    (RING_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : ((64'd1 << RING_BITS) - 64'd1);
  localparam int STALL_LIMIT = 3000;  // cycles with no transfer on either channel
  localparam int TAIL_CYCLES = 20;    // settle time after the last result
  localparam int HOLD_LEN    = 300;   // long receiver hold-off
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [FIELD_W-1:0] x0, x1, x2;
    logic [FIELD_W-1:0] y0, y1, y2;
    logic [FIELD_W-1:0] m0, m1, m2;
    logic               last;
  } share_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] z0, z1, z2;
  } z_shares_t;

  logic clk;
  logic rst_n;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  replicated_share_dot_product #(.RING_BITS(RING_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: one wrapping accumulator per party.
  logic [FIELD_W-1:0] party_acc [PARTIES];
  z_shares_t          z_expected [$];
  z_shares_t          want_z;

  int src_gap_pct;
  int snk_stall_pct;
  int hold_go, hold_seen, hold_left;
  int items_sent, results_seen, rows_closed, errors, idle_cnt, full_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly corner values, with random words in the rest.
  function automatic logic [FIELD_W-1:0] corner_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'hAAAA_AAAA_AAAA_AAAA;
      5: return 64'h5555_5555_5555_5555;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_word(input bit corners);
    return corners ? corner_word() : rand_word();
  endfunction

  function automatic share_item_t make_item(input bit corners, input logic last);
    share_item_t it;
    it.x0   = pick_word(corners);
    it.x1   = pick_word(corners);
    it.x2   = pick_word(corners);
    it.y0   = pick_word(corners);
    it.y1   = pick_word(corners);
    it.y2   = pick_word(corners);
    it.m0   = pick_word(corners);
    it.m1   = pick_word(corners);
    it.m2   = pick_word(corners);
    it.last = last;
    return it;
  endfunction

  // Advance the party accumulators by one item; queue a result on last.
  task automatic mac_predict(input share_item_t it);
    logic [FIELD_W-1:0] xs [PARTIES];
    logic [FIELD_W-1:0] ys [PARTIES];
    logic [FIELD_W-1:0] ms [PARTIES];
    logic [FIELD_W-1:0] term;
    z_shares_t          zx;
    int q;
    xs[0] = it.x0 & RING_MASK; xs[1] = it.x1 & RING_MASK; xs[2] = it.x2 & RING_MASK;
    ys[0] = it.y0 & RING_MASK; ys[1] = it.y1 & RING_MASK; ys[2] = it.y2 & RING_MASK;
    ms[0] = it.m0 & RING_MASK; ms[1] = it.m1 & RING_MASK; ms[2] = it.m2 & RING_MASK;
    for (int p = 0; p < PARTIES; p++) begin
      q = (p + 1) % PARTIES;
      term = xs[p] * ys[p] + xs[p] * ys[q] + xs[q] * ys[p];
      party_acc[p] = (party_acc[p] + term) & RING_MASK;
    end
    if (it.last) begin
      zx.z0 = (party_acc[0] + ms[0]) & RING_MASK;
      zx.z1 = (party_acc[1] + ms[1]) & RING_MASK;
      zx.z2 = (party_acc[2] + ms[2]) & RING_MASK;
      z_expected.push_back(zx);
      for (int p = 0; p < PARTIES; p++) party_acc[p] = '0;
      rows_closed++;
    end
  endtask

  // Offer one item, with a random gap first, and hold it until the transfer.
  task automatic send_item(input share_item_t it);
    int gap;
    gap = 0;
    if (src_gap_pct > 0)
      while ($urandom_range(99) < src_gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.x_share0 <= it.x0;
    in_ch.x_share1 <= it.x1;
    in_ch.x_share2 <= it.x2;
    in_ch.y_share0 <= it.y0;
    in_ch.y_share1 <= it.y1;
    in_ch.y_share2 <= it.y2;
    in_ch.mask0    <= it.m0;
    in_ch.mask1    <= it.m1;
    in_ch.mask2    <= it.m2;
    in_ch.last     <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    mac_predict(it);
  endtask

  // Send items in rows of random length; the final item always closes a row.
  task automatic send_rows(input int n_items, input int max_row, input bit corners);
    int   row_left;
    logic lst;
    row_left = $urandom_range(max_row, 1);
    for (int i = 0; i < n_items; i++) begin
      row_left--;
      lst = (row_left == 0) || (i == n_items - 1);
      send_item(make_item(corners, lst));
      if (lst) row_left = $urandom_range(max_row, 1);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (z_expected.size() != 0) @(posedge clk);
    repeat (LANE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic test_elementwise();
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    send_rows(200, 1, 1'b1);
    drain();
  endtask

  task automatic test_inner_product();
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    send_rows(250, 16, 1'b0);
    drain();
  endtask

  task automatic test_sender_idle();
    src_gap_pct   = 47;
    snk_stall_pct = 0;
    send_rows(250, 8, 1'b1);
    drain();
  endtask

  task automatic test_receiver_stall();
    src_gap_pct   = 0;
    snk_stall_pct = 47;
    send_rows(250, 4, 1'b1);
    drain();
  endtask

  task automatic test_both_idle();
    src_gap_pct   = 37;
    snk_stall_pct = 37;
    send_rows(250, 6, 1'b0);
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_long_hold();
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    hold_go <= hold_go + 1;
    send_rows(150, 3, 1'b1);
    drain();
  endtask

  // Long rows of corner values push every accumulator through its wrap.
  task automatic test_ring_wrap();
    src_gap_pct   = 10;
    snk_stall_pct = 10;
    send_rows(150, 32, 1'b1);
    drain();
  endtask

  task automatic check_share(input int idx, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t result %0d share %0d: expected %h actual %h",
                 $time, results_seen, idx, want, got);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (z_expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, actual %h %h %h", $time,
                   out_ch.z_share0, out_ch.z_share1, out_ch.z_share2);
      end else begin
        want_z = z_expected.pop_front();
        check_share(0, want_z.z0, out_ch.z_share0);
        check_share(1, want_z.z1, out_ch.z_share1);
        check_share(2, want_z.z2, out_ch.z_share2);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_left    <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (rst_n && in_ch.valid && !in_ch.ready)
      full_cycles <= full_cycles + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, idle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bit ok;
    for (int p = 0; p < PARTIES; p++) party_acc[p] = '0;
    src_gap_pct    = 0;
    snk_stall_pct  = 0;
    hold_go        = 0;
    items_sent     = 0;
    results_seen   = 0;
    rows_closed    = 0;
    errors         = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.x_share0 <= '0;
    in_ch.x_share1 <= '0;
    in_ch.x_share2 <= '0;
    in_ch.y_share0 <= '0;
    in_ch.y_share1 <= '0;
    in_ch.y_share2 <= '0;
    in_ch.mask0    <= '0;
    in_ch.mask1    <= '0;
    in_ch.mask2    <= '0;
    in_ch.last     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_elementwise();
    test_inner_product();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_long_hold();
    test_ring_wrap();

    in_ch.valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    ok = (errors == 0) && (z_expected.size() == 0) && (results_seen == rows_closed);
    if (results_seen != rows_closed)
      $display("%0t result count: expected %0d actual %0d", $time, rows_closed,
               results_seen);
    $display("Covered %0d items in %0d rows: elementwise, inner products, wrap-around,",
             items_sent, rows_closed);
    $display("sender gaps, receiver stalls, both, and a long hold (%0d stalled input cycles).",
             full_cycles);
    if (ok)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
